// File: rtl/rpa_pkg.sv
// shared constants, types and tables for the axis rotation block
package rpa_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned R_W       = 34;
  localparam int unsigned NUM_REGS  = 7;
  localparam int unsigned REG_IDX_W = 3;

  localparam int unsigned DEF_FRACTION_BITS = 16;
  localparam int unsigned DEF_CORDIC_STEPS  = 24;

  localparam logic [COORD_W-1:0] AXIS_X_RESET  = 32'h0001_0000;
  localparam logic signed [33:0] ONE_Q30       = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF_TURN     = 34'sh0_8000_0000;
  localparam logic signed [33:0] INV_GAIN_Q30  = 34'sh0_26DD_3B6A;
  localparam logic signed [31:0] EIGHT_OVER_PI = 32'sh28BE_60DC;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5,
    REG_ANGLE    = 3'd6
  } rpa_reg_e;

  typedef struct packed {
    logic                         axis_invalid;
    logic [2:0][COORD_W-1:0]      org;
    logic [8:0][R_W-1:0]          r;
  } rpa_mat_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/rpa_if.sv
// valid/ready channel interfaces for points in and rotated points out
interface rpa_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface rpa_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        axis_invalid;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output axis_invalid, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input axis_invalid, output ready);
endinterface

// File: rtl/rpa_setup.sv
// configuration registers and sequential precompute of the rotation matrix
module rpa_setup import rpa_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  output rpa_mat_t             mat_o,
  output logic                 ready_o
);

  typedef enum logic [10:0] {
    ST_LOAD   = 11'b00000000001,
    ST_NORM   = 11'b00000000010,
    ST_SUMSQ  = 11'b00000000100,
    ST_SQRT   = 11'b00000001000,
    ST_DIV    = 11'b00000010000,
    ST_ANGLE  = 11'b00000100000,
    ST_FOLD   = 11'b00001000000,
    ST_CORDIC = 11'b00010000000,
    ST_MAT    = 11'b00100000000,
    ST_FIN    = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [COORD_W-1:0] cfg_q [NUM_REGS];
  logic [5:0] cnt_q;
  logic [1:0] sub_q;
  logic [3:0] idx_q;
  logic [1:0] dix_q;
  logic       inv_q;
  logic       cfg_hit;

  logic signed [32:0] a_q [3];
  logic [31:0]        m_q;
  logic [63:0]        sq_q, acc_q, v_q, root_q;
  logic [61:0]        num_q;
  logic [31:0]        rem_q, quo_q;
  logic               neg_q;
  logic signed [31:0] k_q [3];
  logic signed [62:0] angp_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic               flip_q;
  logic signed [67:0] mp_q;
  logic signed [33:0] e_q [9];
  logic signed [33:0] sk_q [3];
  logic [8:0][R_W-1:0] r_q;

  // load stage
  logic signed [32:0] ax [3];
  logic [31:0]        aabs [3];
  logic [31:0]        mmax;
  // sum of squares
  logic signed [32:0] sq_sel;
  logic signed [65:0] sq_full;
  // square root
  logic [63:0] v_cur, r_cur, sbit, ssum;
  // divider
  logic [32:0] dtry;
  logic [31:0] div_mag;
  // cordic
  logic signed [33:0] xs, ys, atn, zr;
  // matrix
  logic signed [33:0] c_w, s_w, t_w, ma, mb, mp_sh;
  logic [1:0]         mi, mj, mn;
  logic signed [33:0] rfin [9];

  function automatic logic [3:0] ij_of(input logic [3:0] e);
    logic [3:0] v;
    unique case (e)
      4'd0:    v = {2'd0, 2'd0};
      4'd1:    v = {2'd0, 2'd1};
      4'd2:    v = {2'd0, 2'd2};
      4'd3:    v = {2'd1, 2'd0};
      4'd4:    v = {2'd1, 2'd1};
      4'd5:    v = {2'd1, 2'd2};
      4'd6:    v = {2'd2, 2'd0};
      4'd7:    v = {2'd2, 2'd1};
      4'd8:    v = {2'd2, 2'd2};
      default: v = {2'd0, 2'd0};
    endcase
    return v;
  endfunction

  assign cfg_hit = cfg_we_i && (cfg_index_i <= REG_ANGLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i]   = 33'($signed(cfg_q[REG_AXIS_X + i]));
      aabs[i] = ax[i][32] ? 32'(-ax[i]) : ax[i][31:0];
    end
    mmax = aabs[0];
    if (aabs[1] > mmax) mmax = aabs[1];
    if (aabs[2] > mmax) mmax = aabs[2];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   state_d = (mmax == '0) ? ST_DONE : ST_NORM;
      ST_NORM:   if (m_q[31:30] != 2'b00) state_d = ST_SUMSQ;
      ST_SUMSQ:  if (cnt_q == 6'd3) state_d = ST_SQRT;
      ST_SQRT:   if (cnt_q == 6'd31) state_d = ST_DIV;
      ST_DIV:    if (cnt_q == 6'd63 && dix_q == 2'd2) state_d = ST_ANGLE;
      ST_ANGLE:  state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_CORDIC;
      ST_CORDIC: if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = ST_MAT;
      ST_MAT:    if (idx_q == 4'd11 && sub_q == 2'd1) state_d = ST_FIN;
      ST_FIN:    state_d = ST_DONE;
      ST_DONE:   state_d = ST_DONE;
      default:   state_d = ST_LOAD;
    endcase
    if (cfg_hit) state_d = ST_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
      cfg_q[REG_AXIS_X] <= AXIS_X_RESET;
      cnt_q <= '0;
      sub_q <= '0;
      idx_q <= '0;
      dix_q <= '0;
      inv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) cfg_q[cfg_index_i] <= cfg_wdata_i;
      if (state_q != state_d) cnt_q <= '0;
      else cnt_q <= cnt_q + 6'd1;
      if (state_q == ST_LOAD) begin
        inv_q <= (mmax == '0);
        dix_q <= '0;
        idx_q <= '0;
        sub_q <= '0;
      end
      if (state_q == ST_DIV && cnt_q == 6'd63) dix_q <= dix_q + 2'd1;
      if (state_q == ST_MAT) begin
        if ((idx_q < 4'd9 && sub_q == 2'd2) || (idx_q >= 4'd9 && sub_q == 2'd1)) begin
          sub_q <= '0;
          idx_q <= idx_q + 4'd1;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end
    end
  end

  // sum of squares, square root and divider datapath
  always_comb begin
    sq_sel  = (cnt_q[1:0] == 2'd3) ? a_q[0] : a_q[cnt_q[1:0]];
    sq_full = sq_sel * sq_sel;
    v_cur   = (cnt_q == '0) ? acc_q : v_q;
    r_cur   = (cnt_q == '0) ? '0 : root_q;
    sbit    = 64'h4000_0000_0000_0000 >> {cnt_q[4:0], 1'b0};
    ssum    = r_cur + sbit;
    dtry    = {rem_q, num_q[61]};
    div_mag = a_q[dix_q][32] ? 32'(-a_q[dix_q]) : a_q[dix_q][31:0];
  end

  // cordic and matrix datapath
  always_comb begin
    xs    = x_q >>> cnt_q[4:0];
    ys    = y_q >>> cnt_q[4:0];
    atn   = $signed({2'b00, atan_turns(cnt_q[4:0])});
    zr    = 34'($signed(angp_q[59:28]));
    c_w   = flip_q ? -x_q : x_q;
    s_w   = flip_q ? -y_q : y_q;
    t_w   = ONE_Q30 - c_w;
    mp_sh = 34'(mp_q >>> 30);
    {mi, mj} = ij_of(idx_q);
    mn    = 2'(idx_q - 4'd9);
    if (idx_q < 4'd9) begin
      ma = (sub_q == 2'd0) ? 34'(k_q[mi]) : t_w;
      mb = (sub_q == 2'd0) ? 34'(k_q[mj]) : mp_sh;
    end else begin
      ma = s_w;
      mb = 34'(k_q[mn]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rfin[3*i+j] = e_q[3*i+j] + ((i == j) ? c_w : 34'sd0);
      end
    end
    rfin[1] = rfin[1] - sk_q[2];
    rfin[3] = rfin[3] + sk_q[2];
    rfin[2] = rfin[2] + sk_q[1];
    rfin[6] = rfin[6] - sk_q[1];
    rfin[5] = rfin[5] - sk_q[0];
    rfin[7] = rfin[7] + sk_q[0];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) a_q[i] <= ax[i];
        m_q <= mmax;
      end
      ST_NORM: begin
        if (m_q[31:30] == 2'b00) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] <<< 1;
          m_q <= m_q << 1;
        end
      end
      ST_SUMSQ: begin
        sq_q  <= sq_full[63:0];
        acc_q <= (cnt_q == '0) ? '0 : acc_q + sq_q;
      end
      ST_SQRT: begin
        if (v_cur >= ssum) begin
          v_q    <= v_cur - ssum;
          root_q <= (r_cur >> 1) + sbit;
        end else begin
          v_q    <= v_cur;
          root_q <= r_cur >> 1;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          num_q <= {div_mag, 30'd0};
          rem_q <= '0;
          quo_q <= '0;
          neg_q <= a_q[dix_q][32];
        end else if (cnt_q == 6'd63) begin
          k_q[dix_q] <= neg_q ? -$signed(quo_q) : $signed(quo_q);
        end else begin
          num_q <= num_q << 1;
          if (dtry >= {1'b0, root_q[31:0]}) begin
            rem_q <= 32'(dtry - {1'b0, root_q[31:0]});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= dtry[31:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
        end
      end
      ST_ANGLE: angp_q <= $signed(cfg_q[REG_ANGLE]) * EIGHT_OVER_PI;
      ST_FOLD: begin
        x_q <= INV_GAIN_Q30;
        y_q <= '0;
        if (zr > ONE_Q30) begin
          z_q    <= zr - HALF_TURN;
          flip_q <= 1'b1;
        end else if (zr < -ONE_Q30) begin
          z_q    <= zr + HALF_TURN;
          flip_q <= 1'b1;
        end else begin
          z_q    <= zr;
          flip_q <= 1'b0;
        end
      end
      ST_CORDIC: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atn;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atn;
        end
      end
      ST_MAT: begin
        mp_q <= ma * mb;
        if (idx_q < 4'd9 && sub_q == 2'd2) e_q[idx_q] <= mp_sh;
        if (idx_q >= 4'd9 && sub_q == 2'd1) sk_q[mn] <= mp_sh;
      end
      ST_FIN: begin
        for (int i = 0; i < 9; i++) r_q[i] <= rfin[i];
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign ready_o            = (state_q == ST_DONE);
  assign mat_o.axis_invalid = inv_q;
  assign mat_o.org[0]       = cfg_q[REG_ORIGIN_X];
  assign mat_o.org[1]       = cfg_q[REG_ORIGIN_Y];
  assign mat_o.org[2]       = cfg_q[REG_ORIGIN_Z];
  assign mat_o.r            = r_q;

endmodule

// File: rtl/rpa_xform.sv
// four-stage pipelined 3x4 transform of each point with saturation
module rpa_xform import rpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  rpa_mat_t mat_i,
  input  logic  setup_ready_i,
  rpa_point_if.sink    point_i,
  rpa_result_if.source result_o
);

  localparam int unsigned D_W  = COORD_W + 1;
  localparam int unsigned DH_W = D_W - FRACTION_BITS;
  localparam int unsigned DL_W = FRACTION_BITS + 1;
  localparam int unsigned PH_W = R_W + DH_W;
  localparam int unsigned PL_W = R_W + DL_W;
  localparam int unsigned SH_W = PH_W + 2;
  localparam int unsigned SL_W = PL_W + 2;
  localparam int unsigned V_W  = SH_W + 1;
  localparam int unsigned O_W  = V_W + 1;
  localparam int unsigned RND_SHIFT = 30 - FRACTION_BITS;
  localparam logic signed [SL_W-1:0] RND = SL_W'(64'd1 << 29);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4, take;

  logic signed [D_W-1:0]  d1_q [3];
  logic [COORD_W-1:0]     p1_q [3], p2_q [3], p3_q [3];
  logic                   inv1_q, inv2_q, inv3_q, inv4_q;
  logic signed [PH_W-1:0] ph2_q [9];
  logic signed [PL_W-1:0] pl2_q [9];
  logic signed [SH_W-1:0] hi3_q [3];
  logic signed [SL_W-1:0] lo3_q [3];
  logic [COORD_W-1:0]     o4_q [3];

  logic signed [DH_W-1:0] dh [3];
  logic signed [DL_W-1:0] dl [3];
  logic signed [V_W-1:0]  vs [3], ws [3];
  logic signed [O_W-1:0]  fs [3];
  logic [COORD_W-1:0]     res [3];
  logic [COORD_W-1:0]     pin [3];

  assign en4  = !v4_q || result_o.ready;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign take = point_i.valid && point_i.ready;

  assign point_i.ready = en1 && setup_ready_i;

  assign pin[0] = point_i.point_x;
  assign pin[1] = point_i.point_y;
  assign pin[2] = point_i.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= take;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dh[j] = DH_W'(d1_q[j] >>> FRACTION_BITS);
      dl[j] = $signed({1'b0, d1_q[j][FRACTION_BITS-1:0]});
    end
    for (int i = 0; i < 3; i++) begin
      vs[i] = V_W'(hi3_q[i]) + V_W'(lo3_q[i] >>> FRACTION_BITS);
      ws[i] = vs[i] >>> RND_SHIFT;
      fs[i] = O_W'(ws[i]) + O_W'($signed(mat_i.org[i]));
      if (fs[i][O_W-1:COORD_W-1] == '0 || fs[i][O_W-1:COORD_W-1] == '1) begin
        res[i] = fs[i][COORD_W-1:0];
      end else begin
        res[i] = fs[i][O_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  // stage 1: offset from the axis origin
  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= D_W'($signed(pin[i])) - D_W'($signed(mat_i.org[i]));
        p1_q[i] <= pin[i];
      end
      inv1_q <= mat_i.axis_invalid;
    end
  end

  // stage 2: split partial products
  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph2_q[3*i+j] <= $signed(mat_i.r[3*i+j]) * dh[j];
          pl2_q[3*i+j] <= $signed(mat_i.r[3*i+j]) * dl[j];
        end
        p2_q[i] <= p1_q[i];
      end
      inv2_q <= inv1_q;
    end
  end

  // stage 3: row sums, rounding constant on the low part
  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        hi3_q[i] <= SH_W'(ph2_q[3*i]) + SH_W'(ph2_q[3*i+1]) + SH_W'(ph2_q[3*i+2]);
        lo3_q[i] <= RND + SL_W'(pl2_q[3*i]) + SL_W'(pl2_q[3*i+1]) + SL_W'(pl2_q[3*i+2]);
        p3_q[i]  <= p2_q[i];
      end
      inv3_q <= inv2_q;
    end
  end

  // stage 4: recombine, add origin, saturate; a zero axis passes the point through
  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) o4_q[i] <= inv3_q ? p3_q[i] : res[i];
      inv4_q <= inv3_q;
    end
  end

  assign result_o.valid        = v4_q;
  assign result_o.out_x        = o4_q[0];
  assign result_o.out_y        = o4_q[1];
  assign result_o.out_z        = o4_q[2];
  assign result_o.axis_invalid = inv4_q;

endmodule

// File: rtl/rotate_point_about_axis.sv
// top level of the point rotation about a configured axis
// Rotates each Q16.16 point by the configured angle about the line through
// the origin registers along the axis registers, right-hand rule.
// point_i carries one point per transfer, result_o one rotated point per
// transfer; both are valid/ready channels.
// Configuration uses cfg_we_i, cfg_index_i and cfg_wdata_i; any write to index
// 0..6 restarts the matrix precompute, during which point_i.ready stays low. The
// precompute is dominated by the bit-serial square root and the three 62-step
// divisions; a zero axis goes straight from the load state to done.
// After reset the registers take their reset values and the same precompute
// runs before the first point is taken.
// Each point transfer passes through the four-stage transform to result_o.
// Throughput is one point per cycle while setup is done and result_o is ready.
// When the receiver stalls, the result is held in the output register and the
// pipeline keeps filling its empty stages; nothing is dropped or repeated.
// A zero axis sets axis_invalid and returns the point unchanged.
module rotate_point_about_axis import rpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int unsigned CORDIC_STEPS  = DEF_CORDIC_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  rpa_point_if.sink            point_i,
  rpa_result_if.source         result_o
);

  rpa_mat_t mat;
  logic     setup_ready;

  rpa_setup #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_o       (mat),
    .ready_o     (setup_ready)
  );

  rpa_xform #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_xform (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mat_i         (mat),
    .setup_ready_i (setup_ready),
    .point_i       (point_i),
    .result_o      (result_o)
  );

endmodule
